@@ design/fbpc_pkg.sv @@
// shared constants and sequencer codes for the feather pixel combiner
`timescale 1ns / 1ps

package fbpc_pkg;

   // sizing of the blend arithmetic
   localparam int MAX_SOURCES      = 16;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int DISTANCE_BITS    = 14;
   localparam int SHARP_FRAC_BITS  = 16;

   // field and register widths
   localparam int CHAN_BITS     = 8;
   localparam int DIST_IN_BITS  = 14;
   localparam int SHARP_BITS    = 24;
   localparam int CHAN_SUM_BITS = 29;
   localparam int WSUM_BITS     = 21;

   // distance bits that actually take part
   localparam int DIST_BITS = (DISTANCE_BITS < DIST_IN_BITS) ? DISTANCE_BITS : DIST_IN_BITS;

   // weight holds 0 .. 1.0 inclusive
   localparam int WEIGHT_BITS = WEIGHT_FRAC_BITS + 1;

   // shared multiplier operand widths
   localparam int MUL_A_BITS = SHARP_BITS;
   localparam int MUL_B_BITS = (DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   // weight before clamping, after moving to the weight fraction point
   localparam int LSHIFT = (WEIGHT_FRAC_BITS > SHARP_FRAC_BITS) ?
                           (WEIGHT_FRAC_BITS - SHARP_FRAC_BITS) : 0;
   localparam int RSHIFT = (SHARP_FRAC_BITS > WEIGHT_FRAC_BITS) ?
                           (SHARP_FRAC_BITS - WEIGHT_FRAC_BITS) : 0;
   localparam int SCALED_BITS = MUL_P_BITS + LSHIFT;

   // divider: quotient bits plus the overflow probe bit
   localparam int QUO_BITS  = CHAN_BITS;
   localparam int BIT_BITS  = 4;
   localparam int SUB_BITS  = CHAN_SUM_BITS + 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_PUSH  = 3'd4;

   // multiply steps
   localparam logic [1:0] STEP_WEIGHT = 2'd0;
   localparam logic [1:0] STEP_RED    = 2'd1;
   localparam logic [1:0] STEP_GREEN  = 2'd2;
   localparam logic [1:0] STEP_BLUE   = 2'd3;

   // divide channels
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

endpackage

@@ design/feather_blend_pixel_combiner_core.sv @@
// feather pixel combiner: weighted accumulate and rounded divide on one shared datapath
`timescale 1ns / 1ps

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------------
// req      | in        | req_valid/stall    | req_red, req_green, req_blue, req_distance,
//          |           |                    | req_last_source
// rsp      | out       | rsp_valid/stall    | rsp_out_red, rsp_out_green, rsp_out_blue
// csr      | in        | csr_write_en       | csr_write_data (sharpness)
//
// a request that is not last is accepted and then runs four multiply steps on the
// one shared multiplier; a last request adds one restoring divide per channel on the
// shared subtractor, 9 bit steps and a rounding step each, then a push state that posts the
// result; the divide is skipped when the weight sum is zero and cut short on quotient overflow.
// synchronous reset clears the sums, the sequencer and sets sharpness to 1311.
// a pending response does not block accumulation; only posting a new result waits on rsp_stall.

module feather_blend_pixel_combiner_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fbpc_pkg::CHAN_BITS-1:0]        req_red,
   input  logic [fbpc_pkg::CHAN_BITS-1:0]        req_green,
   input  logic [fbpc_pkg::CHAN_BITS-1:0]        req_blue,
   input  logic [fbpc_pkg::DIST_IN_BITS-1:0]     req_distance,
   input  logic                                  req_last_source,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [fbpc_pkg::CHAN_BITS-1:0]        rsp_out_red,
   output logic [fbpc_pkg::CHAN_BITS-1:0]        rsp_out_green,
   output logic [fbpc_pkg::CHAN_BITS-1:0]        rsp_out_blue,
   input  logic                                  csr_write_en,
   input  logic [fbpc_pkg::SHARP_BITS-1:0]       csr_write_data
);

   localparam logic [fbpc_pkg::SHARP_BITS-1:0] SHARP_RESET = fbpc_pkg::SHARP_BITS'(1311);
   localparam logic [fbpc_pkg::SCALED_BITS-1:0] WEIGHT_ONE =
      fbpc_pkg::SCALED_BITS'(1) << fbpc_pkg::WEIGHT_FRAC_BITS;
   localparam logic [fbpc_pkg::CHAN_SUM_BITS-1:0] CHAN_SUM_MAX = '1;
   localparam logic [fbpc_pkg::WSUM_BITS-1:0] WSUM_MAX = '1;
   localparam logic [fbpc_pkg::BIT_BITS-1:0] BIT_TOP = fbpc_pkg::BIT_BITS'(fbpc_pkg::QUO_BITS);
   localparam logic [fbpc_pkg::CHAN_BITS-1:0] CHAN_MAX = '1;

   // registers
   logic [2:0]                            state_ff, state_in;
   logic [1:0]                            step_ff, step_in;
   logic [fbpc_pkg::BIT_BITS-1:0]         bit_ff, bit_in;
   logic [fbpc_pkg::SHARP_BITS-1:0]       sharp_ff, sharp_in;
   logic [fbpc_pkg::CHAN_BITS-1:0]        red_ff, red_in;
   logic [fbpc_pkg::CHAN_BITS-1:0]        green_ff, green_in;
   logic [fbpc_pkg::CHAN_BITS-1:0]        blue_ff, blue_in;
   logic [fbpc_pkg::DIST_BITS-1:0]        dist_ff, dist_in;
   logic                                  last_ff, last_in;
   logic [fbpc_pkg::WEIGHT_BITS-1:0]      weight_ff, weight_in;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    rsum_ff, rsum_in;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    gsum_ff, gsum_in;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    bsum_ff, bsum_in;
   logic [fbpc_pkg::WSUM_BITS-1:0]        wsum_ff, wsum_in;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    rem_ff, rem_in;
   logic [fbpc_pkg::QUO_BITS-1:0]         quo_ff, quo_in;
   logic [fbpc_pkg::CHAN_BITS-1:0]        res_ff [3];
   logic [fbpc_pkg::CHAN_BITS-1:0]        res_in [3];
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [fbpc_pkg::CHAN_BITS-1:0]        ored_ff, ored_in;
   logic [fbpc_pkg::CHAN_BITS-1:0]        ogreen_ff, ogreen_in;
   logic [fbpc_pkg::CHAN_BITS-1:0]        oblue_ff, oblue_in;

   // datapath signals
   logic [fbpc_pkg::MUL_A_BITS-1:0]       mul_a;
   logic [fbpc_pkg::MUL_B_BITS-1:0]       mul_b;
   logic [fbpc_pkg::MUL_P_BITS-1:0]       mul_p;
   logic [fbpc_pkg::SCALED_BITS-1:0]      scaled;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    acc_sel;
   logic [fbpc_pkg::CHAN_SUM_BITS:0]      acc_sum;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    acc_sat;
   logic [fbpc_pkg::WSUM_BITS:0]          wsum_add;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    div_sel;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    sub_a;
   logic [fbpc_pkg::CHAN_SUM_BITS-1:0]    sub_b;
   logic [fbpc_pkg::SUB_BITS-1:0]         diff;
   logic                                  diff_neg;
   logic                                  diff_zero;
   logic [fbpc_pkg::QUO_BITS:0]           quo_up;
   logic                                  req_fire;
   logic                                  push_ok;

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != fbpc_pkg::ST_IDLE);
   assign push_ok = !rsp_valid_ff || !rsp_stall;

   // shared multiplier: distance times sharpness, then channel times weight
   always_comb begin
      if (step_ff == fbpc_pkg::STEP_WEIGHT) begin
         mul_a = sharp_ff;
         mul_b = fbpc_pkg::MUL_B_BITS'(dist_ff);
      end else begin
         unique case (step_ff)
            fbpc_pkg::STEP_RED:   mul_a = fbpc_pkg::MUL_A_BITS'(red_ff);
            fbpc_pkg::STEP_GREEN: mul_a = fbpc_pkg::MUL_A_BITS'(green_ff);
            default:              mul_a = fbpc_pkg::MUL_A_BITS'(blue_ff);
         endcase
         mul_b = fbpc_pkg::MUL_B_BITS'(weight_ff);
      end
      mul_p = mul_a * mul_b;
   end

   // weight scaling to the weight fraction point and clamp at 1.0
   always_comb begin
      scaled = (fbpc_pkg::SCALED_BITS'(mul_p) << fbpc_pkg::LSHIFT) >> fbpc_pkg::RSHIFT;
      if (scaled > WEIGHT_ONE) begin
         weight_in = fbpc_pkg::WEIGHT_BITS'(WEIGHT_ONE);
      end else begin
         weight_in = scaled[fbpc_pkg::WEIGHT_BITS-1:0];
      end
   end

   // saturating accumulate of the channel product into its sum
   always_comb begin
      unique case (step_ff)
         fbpc_pkg::STEP_RED:   acc_sel = rsum_ff;
         fbpc_pkg::STEP_GREEN: acc_sel = gsum_ff;
         default:              acc_sel = bsum_ff;
      endcase
      acc_sum = {1'b0, acc_sel} + {1'b0, mul_p[fbpc_pkg::CHAN_SUM_BITS-1:0]};
      acc_sat = acc_sum[fbpc_pkg::CHAN_SUM_BITS] ? CHAN_SUM_MAX
                                                 : acc_sum[fbpc_pkg::CHAN_SUM_BITS-1:0];
      wsum_add = {1'b0, wsum_ff} + fbpc_pkg::WSUM_BITS'(weight_ff);
   end

   // shared subtractor: divide trial steps and the rounding compare
   always_comb begin
      unique case (step_ff)
         fbpc_pkg::CH_RED:   div_sel = rsum_ff;
         fbpc_pkg::CH_GREEN: div_sel = gsum_ff;
         default:            div_sel = bsum_ff;
      endcase
      if (state_ff == fbpc_pkg::ST_ROUND) begin
         sub_a = {rem_ff[fbpc_pkg::CHAN_SUM_BITS-2:0], 1'b0};
         sub_b = fbpc_pkg::CHAN_SUM_BITS'(wsum_ff);
      end else begin
         sub_a = (bit_ff == BIT_TOP) ? div_sel : rem_ff;
         sub_b = fbpc_pkg::CHAN_SUM_BITS'(wsum_ff) << bit_ff;
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      diff_neg = diff[fbpc_pkg::SUB_BITS-1];
      diff_zero = (diff == '0);
      quo_up = {1'b0, quo_ff} + (fbpc_pkg::QUO_BITS+1)'(1);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      bit_in = bit_ff;
      sharp_in = csr_write_en ? csr_write_data : sharp_ff;
      red_in = red_ff;
      green_in = green_ff;
      blue_in = blue_ff;
      dist_in = dist_ff;
      last_in = last_ff;
      rsum_in = rsum_ff;
      gsum_in = gsum_ff;
      bsum_in = bsum_ff;
      wsum_in = wsum_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      res_in = res_ff;
      ored_in = ored_ff;
      ogreen_in = ogreen_ff;
      oblue_in = oblue_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         fbpc_pkg::ST_IDLE: begin
            if (req_fire) begin
               red_in = req_red;
               green_in = req_green;
               blue_in = req_blue;
               dist_in = req_distance[fbpc_pkg::DIST_BITS-1:0];
               last_in = req_last_source;
               step_in = fbpc_pkg::STEP_WEIGHT;
               state_in = fbpc_pkg::ST_MUL;
            end
         end
         fbpc_pkg::ST_MUL: begin
            unique case (step_ff)
               fbpc_pkg::STEP_WEIGHT: ;
               fbpc_pkg::STEP_RED: begin
                  rsum_in = acc_sat;
                  wsum_in = wsum_add[fbpc_pkg::WSUM_BITS] ? WSUM_MAX
                                                          : wsum_add[fbpc_pkg::WSUM_BITS-1:0];
               end
               fbpc_pkg::STEP_GREEN: gsum_in = acc_sat;
               default:              bsum_in = acc_sat;
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == fbpc_pkg::STEP_BLUE) begin
               bit_in = BIT_TOP;
               step_in = fbpc_pkg::CH_RED;
               priority if (!last_ff) begin
                  state_in = fbpc_pkg::ST_IDLE;
               end else if (wsum_ff == '0) begin
                  // no weight at all: black
                  res_in[0] = '0;
                  res_in[1] = '0;
                  res_in[2] = '0;
                  state_in = fbpc_pkg::ST_PUSH;
               end else begin
                  state_in = fbpc_pkg::ST_DIV;
               end
            end
         end
         fbpc_pkg::ST_DIV: begin
            if (bit_ff == BIT_TOP) begin
               rem_in = diff_neg ? div_sel : diff[fbpc_pkg::CHAN_SUM_BITS-1:0];
            end else if (!diff_neg) begin
               rem_in = diff[fbpc_pkg::CHAN_SUM_BITS-1:0];
            end
            if (bit_ff != BIT_TOP) begin
               quo_in[bit_ff[fbpc_pkg::BIT_BITS-2:0]] = !diff_neg;
            end
            bit_in = bit_ff - fbpc_pkg::BIT_BITS'(1);
            priority if (bit_ff == BIT_TOP && !diff_neg) begin
               // quotient of 256 or more clamps
               res_in[step_ff] = CHAN_MAX;
               bit_in = BIT_TOP;
               step_in = step_ff + 2'd1;
               if (step_ff == fbpc_pkg::CH_BLUE) begin
                  state_in = fbpc_pkg::ST_PUSH;
               end
            end else if (bit_ff == '0) begin
               state_in = fbpc_pkg::ST_ROUND;
            end else begin
               state_in = fbpc_pkg::ST_DIV;
            end
         end
         fbpc_pkg::ST_ROUND: begin
            // nearest, ties to even
            if (!diff_neg && (!diff_zero || quo_ff[0])) begin
               res_in[step_ff] = quo_up[fbpc_pkg::QUO_BITS] ? CHAN_MAX
                                                           : quo_up[fbpc_pkg::QUO_BITS-1:0];
            end else begin
               res_in[step_ff] = quo_ff;
            end
            bit_in = BIT_TOP;
            step_in = step_ff + 2'd1;
            state_in = (step_ff == fbpc_pkg::CH_BLUE) ? fbpc_pkg::ST_PUSH : fbpc_pkg::ST_DIV;
         end
         fbpc_pkg::ST_PUSH: begin
            if (push_ok) begin
               ored_in = res_ff[0];
               ogreen_in = res_ff[1];
               oblue_in = res_ff[2];
               rsp_valid_in = 1'b1;
               rsum_in = '0;
               gsum_in = '0;
               bsum_in = '0;
               wsum_in = '0;
               state_in = fbpc_pkg::ST_IDLE;
            end
         end
         default: state_in = fbpc_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbpc_pkg::ST_IDLE;
         step_ff <= fbpc_pkg::STEP_WEIGHT;
         bit_ff <= BIT_TOP;
         sharp_ff <= SHARP_RESET;
         rsum_ff <= '0;
         gsum_ff <= '0;
         bsum_ff <= '0;
         wsum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         bit_ff <= bit_in;
         sharp_ff <= sharp_in;
         rsum_ff <= rsum_in;
         gsum_ff <= gsum_in;
         bsum_ff <= bsum_in;
         wsum_ff <= wsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      red_ff <= red_in;
      green_ff <= green_in;
      blue_ff <= blue_in;
      dist_ff <= dist_in;
      last_ff <= last_in;
      if (state_ff == fbpc_pkg::ST_MUL && step_ff == fbpc_pkg::STEP_WEIGHT) begin
         weight_ff <= weight_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
      ored_ff <= ored_in;
      ogreen_ff <= ogreen_in;
      oblue_ff <= oblue_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_red = ored_ff;
   assign rsp_out_green = ogreen_ff;
   assign rsp_out_blue = oblue_ff;

   // checks
   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == fbpc_pkg::ST_PUSH)
      else $error("response posted outside push state");

   a_div_bit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbpc_pkg::ST_DIV) |->
      (bit_ff <= BIT_TOP && step_ff != fbpc_pkg::STEP_BLUE))
      else $error("divider step out of range");

   a_weight_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbpc_pkg::ST_MUL && step_ff != fbpc_pkg::STEP_WEIGHT) |->
      (fbpc_pkg::SCALED_BITS'(weight_ff) <= WEIGHT_ONE))
      else $error("weight above one");

   a_zero_weight_black: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbpc_pkg::ST_PUSH && wsum_ff == '0) |->
      (res_ff[0] == '0 && res_ff[1] == '0 && res_ff[2] == '0))
      else $error("zero weight sum gave a nonzero pixel");

endmodule

@@ dv/feather_blend_pixel_combiner_core_test.sv @@
// self-checking testbench for the feather pixel combiner core
`timescale 1ns / 1ps

module feather_blend_pixel_combiner_core_test;

   localparam int CB = fbpc_pkg::CHAN_BITS;
   localparam int DB = fbpc_pkg::DIST_IN_BITS;
   localparam int SB = fbpc_pkg::SHARP_BITS;

   localparam logic [63:0] CHAN_SUM_MAX = (64'd1 << fbpc_pkg::CHAN_SUM_BITS) - 64'd1;
   localparam logic [63:0] WSUM_MAX     = (64'd1 << fbpc_pkg::WSUM_BITS) - 64'd1;
   localparam logic [63:0] WEIGHT_ONE   = 64'd1 << fbpc_pkg::WEIGHT_FRAC_BITS;
   localparam logic [63:0] CHAN_TOP     = (64'd1 << CB) - 64'd1;
   localparam logic [SB-1:0] SHARP_RESET = 24'd1311;
   localparam logic [SB-1:0] SHARP_TOP   = {SB{1'b1}};
   localparam logic [DB-1:0] DIST_TOP    = {DB{1'b1}};

   // settle time after the queue empties, with margin over how long a last request takes in the block
   localparam int SETTLE_CYCLES = 48;

   // packed pixel: [2] red, [1] green, [0] blue
   typedef logic [2:0][CB-1:0] rgb_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [CB-1:0] req_red = '0;
   logic [CB-1:0] req_green = '0;
   logic [CB-1:0] req_blue = '0;
   logic [DB-1:0] req_distance = '0;
   logic          req_last_source = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [CB-1:0] rsp_out_red;
   logic [CB-1:0] rsp_out_green;
   logic [CB-1:0] rsp_out_blue;
   logic          csr_write_en = 1'b0;
   logic [SB-1:0] csr_write_data = '0;

   // predictor state
   logic [SB-1:0] gain_model = SHARP_RESET;
   logic [63:0]   sum_red = '0;
   logic [63:0]   sum_green = '0;
   logic [63:0]   sum_blue = '0;
   logic [63:0]   sum_weight = '0;
   rgb_type       blend_q[$];

   int err_count = 0;
   bit no_idle = 1'b0;
   int stall_left = 0;

   string chan_name [3] = '{"blue", "green", "red"};

   feather_blend_pixel_combiner_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_distance    (req_distance),
      .req_last_source (req_last_source),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   // weight from distance, clamped to 1.0
   function automatic logic [63:0] pixel_weight(input logic [DB-1:0] d);
      logic [63:0] prod;
      prod = 64'(d[fbpc_pkg::DIST_BITS-1:0]) * 64'(gain_model);
      prod = (prod << fbpc_pkg::LSHIFT) >> fbpc_pkg::RSHIFT;
      return (prod > WEIGHT_ONE) ? WEIGHT_ONE : prod;
   endfunction

   function automatic logic [63:0] sat_sum(input logic [63:0] acc, add, top);
      logic [63:0] s;
      s = acc + add;
      return (s > top) ? top : s;
   endfunction

   // channel sum over weight sum, nearest with ties to even
   function automatic logic [CB-1:0] rounded_share(input logic [63:0] num, den);
      logic [63:0] q;
      logic [63:0] r;
      if (den == 0) return '0;
      q = num / den;
      r = num % den;
      if (2 * r > den || (2 * r == den && q[0])) q++;
      if (q > CHAN_TOP) q = CHAN_TOP;
      return q[CB-1:0];
   endfunction

   // accumulate one accepted request, queue the pixel on the last source
   task automatic absorb_pixel(input logic [CB-1:0] r, g, b, input logic [DB-1:0] d,
                               input logic is_last);
      logic [63:0] w;
      w = pixel_weight(d);
      sum_red    = sat_sum(sum_red, 64'(r) * w, CHAN_SUM_MAX);
      sum_green  = sat_sum(sum_green, 64'(g) * w, CHAN_SUM_MAX);
      sum_blue   = sat_sum(sum_blue, 64'(b) * w, CHAN_SUM_MAX);
      sum_weight = sat_sum(sum_weight, w, WSUM_MAX);
      if (is_last) begin
         blend_q.push_back({rounded_share(sum_red, sum_weight),
                            rounded_share(sum_green, sum_weight),
                            rounded_share(sum_blue, sum_weight)});
         sum_red    = '0;
         sum_green  = '0;
         sum_blue   = '0;
         sum_weight = '0;
      end
   endtask

   // drive one request and wait until it is taken
   task automatic send_pixel(input logic [CB-1:0] r, g, b, input logic [DB-1:0] d,
                             input logic is_last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_distance    <= d;
      req_last_source <= is_last;
      do @(posedge clock); while (req_stall);
      absorb_pixel(r, g, b, d, is_last);
   endtask

   // stop sending, collect every pending pixel, let the block settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (blend_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_sharpness(input logic [SB-1:0] v);
      drain_block();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      gain_model = v;
   endtask

   function automatic logic [CB-1:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CB'($urandom);
      endcase
   endfunction

   function automatic logic [DB-1:0] pick_distance();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return DIST_TOP;
         2:       return DB'($urandom_range(1, 16));
         3, 4:    return DB'($urandom_range(0, 255));
         default: return DB'($urandom);
      endcase
   endfunction

   // runs of random contributions, each closed by a last source
   task automatic random_runs(input int n_items);
      int sent;
      int run_len;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 19))
            0:          run_len = $urandom_range(fbpc_pkg::MAX_SOURCES + 1, 40);
            1, 2, 3, 4: run_len = 1;
            default:    run_len = $urandom_range(2, fbpc_pkg::MAX_SOURCES);
         endcase
         for (int i = 0; i < run_len; i++)
            send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_distance(),
                       i == run_len - 1);
         sent += run_len;
      end
   endtask

   // directed cases at the reset gain: zero weight, clamp, ties to even
   task automatic test_reset_gain();
      send_pixel(8'd255, 8'd255, 8'd255, '0, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd128, DIST_TOP, 1'b1);
      send_pixel(8'd1, 8'd254, 8'd127, 14'd1, 1'b1);
      send_pixel(8'd0, 8'd1, 8'd254, 14'd1, 1'b0);
      send_pixel(8'd1, 8'd2, 8'd255, 14'd1, 1'b1);
      send_pixel(8'd2, 8'd3, 8'd0, 14'd5, 1'b0);
      send_pixel(8'd3, 8'd4, 8'd1, 14'd5, 1'b1);
      send_pixel(8'd200, 8'd10, 8'd50, '0, 1'b0);
      send_pixel(8'd100, 8'd20, 8'd60, 14'd50, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd90, DIST_TOP, 1'b1);
      send_pixel(8'd9, 8'd9, 8'd9, '0, 1'b0);
      send_pixel(8'd9, 8'd9, 8'd9, '0, 1'b1);
   endtask

   // zero gain gives black whatever the distance
   task automatic test_zero_gain();
      set_sharpness('0);
      send_pixel(8'd255, 8'd128, 8'd1, DIST_TOP, 1'b0);
      send_pixel(8'd17, 8'd255, 8'd200, 14'd77, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 14'd1, 1'b1);
   endtask

   // more sources than the sums hold: saturation and quotient clamp
   task automatic test_saturation();
      set_sharpness(SHARP_TOP);
      for (int i = 0; i < 40; i++)
         send_pixel(8'd255, 8'd255, 8'd255, DB'($urandom_range(1, 16383)), i == 39);
      for (int i = 0; i < 36; i++)
         send_pixel(8'd255, 8'd0, 8'd1, DB'($urandom_range(1, 16383)), i == 35);
   endtask

   // random traffic across a sweep of gains, one phase without idling
   task automatic test_gain_sweep();
      logic [SB-1:0] gains [8];
      gains = '{SHARP_TOP, 24'd1, 24'd65536, 24'd65535, SB'($urandom),
                SB'($urandom_range(1, 4095)), 24'd0, SHARP_RESET};
      for (int p = 0; p < 8; p++) begin
         set_sharpness(gains[p]);
         no_idle = (p == 4);
         random_runs(220);
      end
      no_idle = 1'b0;
   endtask

   // response side: stall draw and check against the oldest pixel
   always @(posedge clock) begin : rsp_side
      rgb_type got;
      rgb_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         got = {rsp_out_red, rsp_out_green, rsp_out_blue};
         if (blend_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %0d %0d %0d",
                                      got[2], got[1], got[0]));
         end else begin
            want = blend_q.pop_front();
            for (int c = 0; c < 3; c++)
               if (got[c] !== want[c])
                  report_mismatch($sformatf("%s got %0d want %0d",
                                            chan_name[c], got[c], want[c]));
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 3);
         rsp_stall <= (stall_left > 0);
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("feather_blend_pixel_combiner_core_test: errors");
      $finish;
   end

   // test sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_gain();
      test_zero_gain();
      test_saturation();
      test_gain_sweep();
      drain_block();
      if (blend_q.size() != 0)
         report_mismatch($sformatf("%0d pixels never came", blend_q.size()));
      if (err_count == 0)
         $display("feather_blend_pixel_combiner_core_test: clean");
      else
         $display("feather_blend_pixel_combiner_core_test: errors");
      $finish;
   end

endmodule
